// ----- src/isu_pkg.sv -----
// Shared constants, types and the decision record of the Ising spin update block.
package isu_pkg;

  localparam int LATTICE_ROWS = 64;
  localparam int LATTICE_COLS = 64;
  localparam int SITE_COUNT   = LATTICE_ROWS * LATTICE_COLS;

  localparam int ROW_W      = $clog2(LATTICE_ROWS);
  localparam int COL_W      = $clog2(LATTICE_COLS);
  localparam int SITE_ROW_W = 6;
  localparam int SITE_COL_W = 6;
  localparam int RAND_W     = 16;
  localparam int LEVEL_W    = 17;
  localparam int NUM_LEVELS = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int MAG_W      = 14;
  localparam int BOND_W     = 15;
  localparam int NEIGHBORS  = 4;

  // Request codes carried on req_type.
  localparam logic REQ_PROPOSE = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [COL_W-1:0]          col_t;
  typedef logic [LATTICE_COLS-1:0]   row_bits_t;
  typedef logic [LEVEL_W-1:0]        level_t;
  typedef level_t [NUM_LEVELS-1:0]   level_bank_t;
  typedef logic signed [MAG_W-1:0]   mag_t;
  typedef logic signed [BOND_W-1:0]  bond_t;

  localparam mag_t  MAG_RESET   = MAG_W'(SITE_COUNT);
  localparam bond_t BOND_RESET  = BOND_W'(2 * SITE_COUNT);
  localparam level_t LEVEL_ONE  = LEVEL_W'(65536);

  // Outcome of one item, handed from the update logic to the control.
  typedef struct packed {
    logic      flip;
    logic      accepted;
    logic      spin_new;
    mag_t      mag_delta;
    bond_t     bond_delta;
    row_bits_t row_new;
  } decision_t;

endpackage

// ----- src/isu_lattice_ram.sv -----
// Row-wide lattice memory with two read ports, one write port and row valid bits.
module isu_lattice_ram import isu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rd_a_en_i,
  input  row_t      rd_a_addr_i,
  input  logic      rd_b_en_i,
  input  row_t      rd_b_addr_i,
  input  logic      wr_en_i,
  input  row_t      wr_addr_i,
  input  row_bits_t wr_data_i,
  output row_bits_t rd_a_data_o,
  output row_bits_t rd_b_data_o
);

  row_bits_t                 mem_q [LATTICE_ROWS];
  logic [LATTICE_ROWS-1:0]   row_valid_q;
  row_bits_t                 a_raw_q, b_raw_q;
  row_bits_t                 a_fwd_data_q, b_fwd_data_q;
  logic                      a_fwd_q, b_fwd_q;
  logic                      a_valid_q, b_valid_q;

  // The array read returns the old contents; a write to the same row in the
  // same cycle is forwarded from the hold registers instead.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_a_en_i) begin
      a_raw_q      <= mem_q[rd_a_addr_i];
      a_fwd_data_q <= wr_data_i;
    end
    if (rd_b_en_i) begin
      b_raw_q      <= mem_q[rd_b_addr_i];
      b_fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      a_fwd_q     <= 1'b0;
      b_fwd_q     <= 1'b0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_a_en_i) begin
        a_fwd_q   <= wr_en_i && (wr_addr_i == rd_a_addr_i);
        a_valid_q <= row_valid_q[rd_a_addr_i];
      end
      if (rd_b_en_i) begin
        b_fwd_q   <= wr_en_i && (wr_addr_i == rd_b_addr_i);
        b_valid_q <= row_valid_q[rd_b_addr_i];
      end
    end
  end

  // A row never written reads as its reset contents: every spin +1.
  assign rd_a_data_o = a_fwd_q ? a_fwd_data_q : (a_valid_q ? a_raw_q : '1);
  assign rd_b_data_o = b_fwd_q ? b_fwd_data_q : (b_valid_q ? b_raw_q : '1);

endmodule

// ----- src/isu_update.sv -----
// Neighbor sum, acceptance test and total deltas for one lattice site.
module isu_update import isu_pkg::*; (
  input  logic              req_type_i,
  input  col_t              col_i,
  input  row_bits_t         site_row_i,
  input  logic              up_spin_i,
  input  row_bits_t         down_row_i,
  input  logic [RAND_W-1:0] random_value_i,
  input  logic              write_spin_i,
  input  level_bank_t       levels_i,
  output decision_t         dec_o
);

  localparam col_t  COL_LAST = col_t'(LATTICE_COLS - 1);
  localparam logic [2:0] NB_COUNT = 3'(NEIGHBORS);
  localparam bond_t BOND_BIAS = BOND_W'(2 * NEIGHBORS);
  localparam mag_t  MAG_STEP  = MAG_W'(2);

  col_t       col_left, col_right;
  logic       spin;
  logic [2:0] up_count;
  logic [2:0] sel;
  bond_t      up4;
  logic       below_level;
  logic       flip;

  always_comb begin
    col_left  = (col_i == '0) ? COL_LAST : col_i - col_t'(1);
    col_right = (col_i == COL_LAST) ? '0 : col_i + col_t'(1);
    spin      = site_row_i[col_i];

    // Number of +1 neighbors; the neighbor sum is twice this minus four.
    up_count = 3'(up_spin_i) + 3'(down_row_i[col_i]) + 3'(site_row_i[col_left])
             + 3'(site_row_i[col_right]);

    // Level index is (spin * sum + 4) / 2.
    sel = spin ? up_count : NB_COUNT - up_count;
    below_level = {1'b0, random_value_i} < levels_i[sel];

    flip = (req_type_i == REQ_WRITE) ? (spin != write_spin_i) : below_level;

    up4 = BOND_W'({up_count, 2'b00});

    dec_o.flip       = flip;
    dec_o.accepted   = (req_type_i == REQ_PROPOSE) && below_level;
    dec_o.spin_new   = spin ^ flip;
    dec_o.mag_delta  = spin ? -MAG_STEP : MAG_STEP;
    dec_o.bond_delta = spin ? (BOND_BIAS - up4) : (up4 - BOND_BIAS);
    dec_o.row_new    = site_row_i;
    dec_o.row_new[col_i] = spin ^ flip;
  end

endmodule

// ----- src/ising_metropolis_spin_update.sv -----
// Top level of the Metropolis spin update: control, totals and acceptance levels.
// An item passes the read-down and decide states; the result strobe is registered in decide.
// Busy is high for the cycle after each accept, while the second round of row reads goes
// through the two-port lattice memory; a new item may enter during the decide state.
// Reset: asynchronous; lattice, totals and levels are usable at once, no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ising_metropolis_spin_update import isu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item channel.
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type_i,
  input  logic [SITE_ROW_W-1:0] site_row_i,
  input  logic [SITE_COL_W-1:0] site_col_i,
  input  logic [RAND_W-1:0]     random_value_i,
  input  logic                  write_spin_i,
  // Result channel.
  output logic                  result_valid_o,
  output logic                  flipped_o,
  output logic                  spin_after_o,
  output mag_t                  magnetization_sum_o,
  output bond_t                 bond_sum_o,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  level_t                cfg_data_i
);

  localparam row_t ROW_LAST = row_t'(LATTICE_ROWS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_DN,
    ST_DECIDE
  } state_e;

  state_e      state_q, state_d;
  logic        accept;

  // Item captured at accept time.
  logic              req_type_q;
  row_t              row_q;
  col_t              col_q;
  logic [RAND_W-1:0] rnd_q;
  logic              wsp_q;
  logic              up_spin_q;

  row_t        row_in, col_in_row;
  col_t        col_in;
  row_t        row_up_in, row_dn;

  logic        rd_a_en, rd_b_en;
  row_t        rd_a_addr;
  row_bits_t   rd_a_data, rd_b_data;
  logic        wr_en;

  decision_t   dec;
  level_bank_t levels_q;
  mag_t        mag_q;
  bond_t       bond_q;
  logic        result_valid_q, flipped_q, spin_after_q;

  // A new item may enter while the previous one is in its decide cycle; its
  // row reads then meet the write-back, which the memory forwards.
  assign busy   = (state_q == ST_READ_DN);
  assign accept = start && !busy;

  // Site indices wrap onto the lattice.
  assign row_in     = row_t'(site_row_i % LATTICE_ROWS);
  assign col_in     = col_t'(site_col_i % LATTICE_COLS);
  assign col_in_row = row_in;
  assign row_up_in  = (row_in == '0) ? ROW_LAST : row_in - row_t'(1);
  assign row_dn     = (row_q == ROW_LAST) ? '0 : row_q + row_t'(1);

  // Port B reads the site row at accept and holds it until the decision.
  // Port A reads the row above at accept, then the row below in the cycle after.
  assign rd_b_en   = accept;
  assign rd_a_en   = accept || (state_q == ST_READ_DN);
  assign rd_a_addr = accept ? row_up_in : row_dn;
  assign wr_en     = (state_q == ST_DECIDE) && dec.flip;

  isu_lattice_ram u_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_a_en_i   (rd_a_en),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_en_i   (rd_b_en),
    .rd_b_addr_i (col_in_row),
    .wr_en_i     (wr_en),
    .wr_addr_i   (row_q),
    .wr_data_i   (dec.row_new),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data)
  );

  isu_update u_update (
    .req_type_i     (req_type_q),
    .col_i          (col_q),
    .site_row_i     (rd_b_data),
    .up_spin_i      (up_spin_q),
    .down_row_i     (rd_a_data),
    .random_value_i (rnd_q),
    .write_spin_i   (wsp_q),
    .levels_i       (levels_q),
    .dec_o          (dec)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    state_d = accept ? ST_READ_DN : ST_IDLE;
      ST_READ_DN: state_d = ST_DECIDE;
      ST_DECIDE:  state_d = accept ? ST_READ_DN : ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // State, running totals and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      mag_q          <= MAG_RESET;
      bond_q         <= BOND_RESET;
      result_valid_q <= 1'b0;
      flipped_q      <= 1'b0;
      spin_after_q   <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == ST_DECIDE);
      if (state_q == ST_DECIDE) begin
        flipped_q    <= dec.accepted;
        spin_after_q <= dec.spin_new;
        if (dec.flip) begin
          mag_q  <= mag_q + dec.mag_delta;
          bond_q <= bond_q + dec.bond_delta;
        end
      end
    end
  end

  // Item fields and the spin above the site, kept for the decide cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_type_i;
      row_q      <= row_in;
      col_q      <= col_in;
      rnd_q      <= random_value_i;
      wsp_q      <= write_spin_i;
    end
    if (state_q == ST_READ_DN) begin
      up_spin_q <= rd_a_data[col_q];
    end
  end

  // Acceptance levels; writes to indexes past the last level are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= {NUM_LEVELS{LEVEL_ONE}};
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < NUM_LEVELS)) begin
      levels_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign result_valid_o      = result_valid_q;
  assign flipped_o           = flipped_q;
  assign spin_after_o        = spin_after_q;
  assign magnetization_sum_o = mag_q;
  assign bond_sum_o          = bond_q;

`ifndef NO_ASSERTIONS
  // No item is accepted while busy, so result strobes never touch.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe high in two consecutive cycles");

  // An accepted item always goes through the second read round.
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ_DN) && busy)
    else $error("accepted item did not enter the second read round");

  // The magnetization only moves on a flip in the decide cycle.
  a_mag_on_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mag_q != $past(mag_q)) |-> $past((state_q == ST_DECIDE) && dec.flip))
    else $error("magnetization changed without a flip");

  // A proposal reported as flipped came with a memory write-back.
  a_flip_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DECIDE) && dec.accepted) |-> wr_en)
    else $error("accepted proposal not written back");
`endif

endmodule
